// ----- sv/pfsc_pkg.sv -----
// Shared constants, types and helpers of the particle select and count block.
`timescale 1ns / 1ps

package pfsc_pkg;

    localparam int MAX_PARTICLES = 512;

    localparam int IDX_W  = $clog2(MAX_PARTICLES);
    localparam int CNT_W  = $clog2(MAX_PARTICLES + 1);
    localparam int CODE_W = 31;
    localparam int STATE_W = 3;
    localparam int MOM_W  = 24;
    localparam int SQ_W   = 2 * MOM_W;
    localparam int SUM_W  = SQ_W + 1;

    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = CODE_W;

    localparam logic [CFG_IDX_W-1:0] REG_MATCH_CODE  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_MATCH_STATE = CFG_IDX_W'(1);

    localparam logic [STATE_W-1:0] ST_INITIAL = STATE_W'(0);
    localparam logic [STATE_W-1:0] ST_FINAL   = STATE_W'(1);
    localparam logic [STATE_W-1:0] ST_ANY     = STATE_W'(6);

    localparam logic [CODE_W-1:0] CODE_NU_E    = CODE_W'(12);
    localparam logic [CODE_W-1:0] CODE_NU_MU   = CODE_W'(14);
    localparam logic [CODE_W-1:0] CODE_NU_TAU  = CODE_W'(16);
    localparam logic [CODE_W-1:0] CODE_LEP_E   = CODE_W'(11);
    localparam logic [CODE_W-1:0] CODE_LEP_MU  = CODE_W'(13);
    localparam logic [CODE_W-1:0] CODE_LEP_TAU = CODE_W'(15);
    localparam logic [CODE_W-1:0] CODE_MESON_LO = CODE_W'(111);
    localparam logic [CODE_W-1:0] CODE_MESON_HI = CODE_W'(557);

    typedef struct packed {
        logic            matched;
        logic            neutrino;
        logic            meson;
        logic            lepton;
        logic            last;
        logic [SQ_W-1:0] sq_x;
        logic [SQ_W-1:0] sq_y;
        logic [SQ_W-1:0] sq_z;
    } pfsc_item_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] c);
        return (c < CNT_W'(MAX_PARTICLES)) ? c + CNT_W'(1) : c;
    endfunction

    function automatic logic [MOM_W-1:0] mom_abs(input logic signed [MOM_W-1:0] v);
        return v[MOM_W-1] ? MOM_W'(-v) : MOM_W'(v);
    endfunction

endpackage

// ----- sv/pfsc_front.sv -----
// Input register, filter classification and momentum squares stage.
`timescale 1ns / 1ps

module pfsc_front
    import pfsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [CODE_W-1:0]  code,
    input  logic [STATE_W-1:0]        pstate,
    input  logic signed [MOM_W-1:0]   mom_x,
    input  logic signed [MOM_W-1:0]   mom_y,
    input  logic signed [MOM_W-1:0]   mom_z,
    input  logic                      last_particle,
    input  logic signed [CODE_W-1:0]  match_code,
    input  logic [STATE_W-1:0]        match_state,
    output logic                      item_valid,
    output pfsc_item_t                item,
    input  logic                      item_ready
);

    logic                     s1_valid_reg, s1_valid_next;
    logic signed [CODE_W-1:0] s1_code_reg;
    logic [STATE_W-1:0]       s1_pstate_reg;
    logic signed [MOM_W-1:0]  s1_mx_reg, s1_my_reg, s1_mz_reg;
    logic                     s1_last_reg;
    logic                     s2_valid_reg, s2_valid_next;
    pfsc_item_t               s2_item_reg, s2_item_next;
    logic                     s2_ready, s1_ready, in_fire;
    logic [CODE_W-1:0]        mag;
    logic [MOM_W-1:0]         ax, ay, az;
    logic                     state_ok, code_ok;

    assign s2_ready = !s2_valid_reg || item_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;
    assign in_fire  = in_valid && s1_ready;

    assign s1_valid_next = in_fire || (s1_valid_reg && !s2_ready);
    assign s2_valid_next = s2_ready ? s1_valid_reg : s2_valid_reg;

    always_comb
    begin
        mag = s1_code_reg[CODE_W-1] ? CODE_W'(-s1_code_reg) : CODE_W'(s1_code_reg);
        ax  = mom_abs(s1_mx_reg);
        ay  = mom_abs(s1_my_reg);
        az  = mom_abs(s1_mz_reg);
        state_ok = (match_state >= ST_ANY) || (s1_pstate_reg == match_state);
        code_ok  = (match_code == '0) || (s1_code_reg == match_code);
        s2_item_next.matched  = state_ok && code_ok;
        s2_item_next.neutrino = (s1_pstate_reg == ST_INITIAL)
                             && ((mag == CODE_NU_E) || (mag == CODE_NU_MU)
                                 || (mag == CODE_NU_TAU));
        s2_item_next.meson    = (s1_pstate_reg == ST_FINAL)
                             && (mag >= CODE_MESON_LO) && (mag <= CODE_MESON_HI);
        s2_item_next.lepton   = (s1_pstate_reg == ST_FINAL)
                             && ((mag == CODE_LEP_E) || (mag == CODE_LEP_MU)
                                 || (mag == CODE_LEP_TAU));
        s2_item_next.last     = s1_last_reg;
        s2_item_next.sq_x     = SQ_W'(ax) * SQ_W'(ax);
        s2_item_next.sq_y     = SQ_W'(ay) * SQ_W'(ay);
        s2_item_next.sq_z     = SQ_W'(az) * SQ_W'(az);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            s2_valid_reg <= s2_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            s1_code_reg   <= code;
            s1_pstate_reg <= pstate;
            s1_mx_reg     <= mom_x;
            s1_my_reg     <= mom_y;
            s1_mz_reg     <= mom_z;
            s1_last_reg   <= last_particle;
        end
        if (s2_ready && s1_valid_reg)
        begin
            s2_item_reg <= s2_item_next;
        end
    end

    assign item_valid = s2_valid_reg;
    assign item       = s2_item_reg;

endmodule

// ----- sv/pfsc_accum.sv -----
// Running event state, hardest-match search and result register.
`timescale 1ns / 1ps

module pfsc_accum
    import pfsc_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     item_valid,
    input  pfsc_item_t               item,
    output logic                     item_ready,
    output logic                     out_valid,
    input  logic                     out_ready,
    output logic [CNT_W-1:0]         match_count,
    output logic signed [IDX_W:0]    hardest_index,
    output logic [IDX_W-1:0]         neutrino_index,
    output logic                     neutrino_found,
    output logic [CNT_W-1:0]         meson_count,
    output logic [CNT_W-1:0]         lepton_count
);

    logic [CNT_W-1:0] pos_reg, pos_next;
    logic [CNT_W-1:0] matches_reg, matches_next;
    logic [SUM_W-1:0] best_sq_reg, best_sq_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic             found_reg, found_next;
    logic [IDX_W-1:0] first_nu_reg, first_nu_next;
    logic             nu_seen_reg, nu_seen_next;
    logic [CNT_W-1:0] mesons_reg, mesons_next;
    logic [CNT_W-1:0] leptons_reg, leptons_next;

    logic             out_valid_reg, out_valid_next;
    logic [CNT_W-1:0] out_matches_reg;
    logic             out_found_reg;
    logic [IDX_W-1:0] out_best_idx_reg;
    logic [IDX_W-1:0] out_nu_idx_reg;
    logic             out_nu_seen_reg;
    logic [CNT_W-1:0] out_mesons_reg;
    logic [CNT_W-1:0] out_leptons_reg;

    logic             slot_free, fire, better;
    logic [IDX_W-1:0] idx;
    logic [SUM_W-1:0] sum;
    logic [CNT_W-1:0] matches_upd, mesons_upd, leptons_upd;
    logic [SUM_W-1:0] best_sq_upd;
    logic [IDX_W-1:0] best_idx_upd, first_nu_upd;
    logic             found_upd, nu_seen_upd;

    assign slot_free  = !out_valid_reg || out_ready;
    assign item_ready = !item.last || slot_free;
    assign fire       = item_valid && item_ready;

    always_comb
    begin
        idx = (pos_reg >= CNT_W'(MAX_PARTICLES)) ? IDX_W'(MAX_PARTICLES - 1)
                                                 : pos_reg[IDX_W-1:0];
        sum = SUM_W'(item.sq_x) + SUM_W'(item.sq_y) + SUM_W'(item.sq_z);
        better = !found_reg || (sum > best_sq_reg);

        matches_upd  = item.matched ? sat_inc(matches_reg) : matches_reg;
        found_upd    = found_reg || item.matched;
        best_sq_upd  = (item.matched && better) ? sum : best_sq_reg;
        best_idx_upd = (item.matched && better) ? idx : best_idx_reg;
        nu_seen_upd  = nu_seen_reg || item.neutrino;
        first_nu_upd = (item.neutrino && !nu_seen_reg) ? idx : first_nu_reg;
        mesons_upd   = item.meson ? sat_inc(mesons_reg) : mesons_reg;
        leptons_upd  = item.lepton ? sat_inc(leptons_reg) : leptons_reg;

        pos_next      = pos_reg;
        matches_next  = matches_reg;
        best_sq_next  = best_sq_reg;
        best_idx_next = best_idx_reg;
        found_next    = found_reg;
        first_nu_next = first_nu_reg;
        nu_seen_next  = nu_seen_reg;
        mesons_next   = mesons_reg;
        leptons_next  = leptons_reg;

        if (fire)
        begin
            if (item.last)
            begin
                pos_next      = '0;
                matches_next  = '0;
                best_sq_next  = '0;
                best_idx_next = '0;
                found_next    = 1'b0;
                first_nu_next = '0;
                nu_seen_next  = 1'b0;
                mesons_next   = '0;
                leptons_next  = '0;
            end
            else
            begin
                pos_next      = sat_inc(pos_reg);
                matches_next  = matches_upd;
                best_sq_next  = best_sq_upd;
                best_idx_next = best_idx_upd;
                found_next    = found_upd;
                first_nu_next = first_nu_upd;
                nu_seen_next  = nu_seen_upd;
                mesons_next   = mesons_upd;
                leptons_next  = leptons_upd;
            end
        end

        if (fire && item.last)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg       <= '0;
            matches_reg   <= '0;
            best_sq_reg   <= '0;
            best_idx_reg  <= '0;
            found_reg     <= 1'b0;
            first_nu_reg  <= '0;
            nu_seen_reg   <= 1'b0;
            mesons_reg    <= '0;
            leptons_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pos_reg       <= pos_next;
            matches_reg   <= matches_next;
            best_sq_reg   <= best_sq_next;
            best_idx_reg  <= best_idx_next;
            found_reg     <= found_next;
            first_nu_reg  <= first_nu_next;
            nu_seen_reg   <= nu_seen_next;
            mesons_reg    <= mesons_next;
            leptons_reg   <= leptons_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire && item.last)
        begin
            out_matches_reg  <= matches_upd;
            out_found_reg    <= found_upd;
            out_best_idx_reg <= best_idx_upd;
            out_nu_idx_reg   <= first_nu_upd;
            out_nu_seen_reg  <= nu_seen_upd;
            out_mesons_reg   <= mesons_upd;
            out_leptons_reg  <= leptons_upd;
        end
    end

    assign out_valid      = out_valid_reg;
    assign match_count    = out_matches_reg;
    assign hardest_index  = out_found_reg ? {1'b0, out_best_idx_reg} : '1;
    assign neutrino_index = out_nu_idx_reg;
    assign neutrino_found = out_nu_seen_reg;
    assign meson_count    = out_mesons_reg;
    assign lepton_count   = out_leptons_reg;

endmodule

// ----- sv/particle_filter_select_count.sv -----
// Top level of the particle select and count block.
// Throughput: one particle per cycle; stalls only while an event result waits on out_ready.
// The result is registered: a marked last particle passes the input register, the square
// stage and then the accumulate and result register before out_valid rises.
// Reset: match_code clears to 0, match_state to 6 (any), running event state clears.
// Configuration writes are always accepted (cfg_ready stays high).
`timescale 1ns / 1ps

module particle_filter_select_count
    import pfsc_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [CFG_IDX_W-1:0]      cfg_index,
    input  logic [CFG_DATA_W-1:0]     cfg_data,
    input  logic                      in_valid,
    output logic                      in_ready,
    input  logic signed [CODE_W-1:0]  code,
    input  logic [STATE_W-1:0]        pstate,
    input  logic signed [MOM_W-1:0]   mom_x,
    input  logic signed [MOM_W-1:0]   mom_y,
    input  logic signed [MOM_W-1:0]   mom_z,
    input  logic                      last_particle,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [CNT_W-1:0]          match_count,
    output logic signed [IDX_W:0]     hardest_index,
    output logic [IDX_W-1:0]          neutrino_index,
    output logic                      neutrino_found,
    output logic [CNT_W-1:0]          meson_count,
    output logic [CNT_W-1:0]          lepton_count
);

    logic signed [CODE_W-1:0] match_code_reg, match_code_next;
    logic [STATE_W-1:0]       match_state_reg, match_state_next;
    logic                     cfg_fire;
    logic                     item_valid, item_ready;
    pfsc_item_t               item;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;

    always_comb
    begin
        match_code_next  = match_code_reg;
        match_state_next = match_state_reg;
        if (cfg_fire)
        begin
            unique case (cfg_index)
                REG_MATCH_CODE:  match_code_next  = CODE_W'(cfg_data);
                REG_MATCH_STATE: match_state_next = cfg_data[STATE_W-1:0];
                default:         match_code_next  = match_code_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_code_reg  <= '0;
            match_state_reg <= ST_ANY;
        end
        else
        begin
            match_code_reg  <= match_code_next;
            match_state_reg <= match_state_next;
        end
    end

    pfsc_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .code          (code),
        .pstate        (pstate),
        .mom_x         (mom_x),
        .mom_y         (mom_y),
        .mom_z         (mom_z),
        .last_particle (last_particle),
        .match_code    (match_code_reg),
        .match_state   (match_state_reg),
        .item_valid    (item_valid),
        .item          (item),
        .item_ready    (item_ready)
    );

    pfsc_accum u_accum (
        .clk            (clk),
        .rst_n          (rst_n),
        .item_valid     (item_valid),
        .item           (item),
        .item_ready     (item_ready),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .match_count    (match_count),
        .hardest_index  (hardest_index),
        .neutrino_index (neutrino_index),
        .neutrino_found (neutrino_found),
        .meson_count    (meson_count),
        .lepton_count   (lepton_count)
    );

endmodule

// ----- sv/pfsc_checker.sv -----
// Port-level assertions for the particle select and count block, with bind.
`timescale 1ns / 1ps

module pfsc_checker
    import pfsc_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     out_valid,
    input logic                     out_ready,
    input logic [CNT_W-1:0]         match_count,
    input logic signed [IDX_W:0]    hardest_index,
    input logic [IDX_W-1:0]         neutrino_index,
    input logic                     neutrino_found,
    input logic [CNT_W-1:0]         meson_count,
    input logic [CNT_W-1:0]         lepton_count
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(match_count)
            && $stable(hardest_index) && $stable(neutrino_index))
        else $error("result changed while stalled");

    a_none_matched: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((match_count == '0) == (hardest_index == '1)))
        else $error("hardest index disagrees with match count");

    a_no_neutrino: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !neutrino_found |-> neutrino_index == '0)
        else $error("neutrino index set without a neutrino");

    a_saturate: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (match_count <= CNT_W'(MAX_PARTICLES))
            && (meson_count <= CNT_W'(MAX_PARTICLES))
            && (lepton_count <= CNT_W'(MAX_PARTICLES)))
        else $error("count above saturation limit");

endmodule

bind particle_filter_select_count pfsc_checker u_pfsc_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .match_count    (match_count),
    .hardest_index  (hardest_index),
    .neutrino_index (neutrino_index),
    .neutrino_found (neutrino_found),
    .meson_count    (meson_count),
    .lepton_count   (lepton_count)
);
